// ===== rtl/urd_pkg.sv =====
package urd_pkg;

  // Datapath width of the divider core (8..64)
  localparam int DATA_WIDTH = 64;

  // Width of the payload fields on the ports
  localparam int FIELD_W = 64;

  // Narrow mode width, never above the datapath width
  localparam int NARROW_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  // Operand mask for narrow mode at datapath width
  localparam logic [DATA_WIDTH-1:0] NARROW_MASK =
    DATA_WIDTH'((65'd1 << NARROW_W) - 65'd1);

  // Width select codes
  localparam logic CMD_WIDE   = 1'b0;
  localparam logic CMD_NARROW = 1'b1;

  // Request item
  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] numerator;
    logic [FIELD_W-1:0] denominator;
  } req_item_t;

  // Result item
  typedef struct packed {
    logic [FIELD_W-1:0] quot;
    logic [FIELD_W-1:0] remain;
  } rsp_item_t;

  // Pipeline stage contents: partial remainder, shared dividend/quotient
  // shift register, divisor and mode
  typedef struct packed {
    logic                  valid;
    logic                  narrow;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] nq;
    logic [DATA_WIDTH-1:0] dvsr;
  } stage_t;

endpackage

// ===== rtl/unsigned_restoring_divider.sv =====
// Structure: one input register, then one shift-subtract stage per quotient bit.
// Throughput: one item per cycle; the whole pipeline holds while a result
//   waits at the output, so a stall drops and repeats nothing.
// Reset (rst, synchronous): clears every stage valid bit; payload is kept.
module unsigned_restoring_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  urd_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output urd_pkg::rsp_item_t rsp
);

  localparam int DW = urd_pkg::DATA_WIDTH;

  urd_pkg::stage_t pipe [DW+1];
  logic            advance;
  logic [DW-1:0]   num_in;
  logic [DW-1:0]   den_in;
  logic [DW-1:0]   quot_w;

  // Move the whole pipeline when the output slot is free or being taken
  assign advance   = ~pipe[DW].valid | rsp_ready;
  assign req_ready = advance;

  // Mask operands to the selected width
  always_comb begin
    num_in = req.numerator[DW-1:0];
    den_in = req.denominator[DW-1:0];
    if (req.cmd == urd_pkg::CMD_NARROW) begin
      num_in = num_in & urd_pkg::NARROW_MASK;
      den_in = den_in & urd_pkg::NARROW_MASK;
    end
  end

  // Input register: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (advance) begin
      pipe[0].valid <= req_valid;
    end
  end

  // Input register: payload
  always_ff @(posedge clk) begin
    if (advance) begin
      pipe[0].narrow <= (req.cmd == urd_pkg::CMD_NARROW);
      pipe[0].rem    <= '0;
      pipe[0].nq     <= num_in;
      pipe[0].dvsr   <= den_in;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 1; k <= DW; k++) begin : g_step
    urd_step u_step (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .prev    (pipe[k-1]),
      .cur     (pipe[k])
    );
  end

  // Trim the quotient to the selected width and zero-extend
  always_comb begin
    quot_w = pipe[DW].nq;
    if (pipe[DW].narrow) begin
      quot_w = quot_w & urd_pkg::NARROW_MASK;
    end
  end

  assign rsp_valid  = pipe[DW].valid;
  assign rsp.quot   = urd_pkg::FIELD_W'(quot_w);
  assign rsp.remain = urd_pkg::FIELD_W'(pipe[DW].rem);

endmodule

// ===== rtl/urd_step.sv =====
module urd_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  urd_pkg::stage_t prev,
  output urd_pkg::stage_t cur
);

  logic [urd_pkg::DATA_WIDTH:0]   trial;
  logic [urd_pkg::DATA_WIDTH:0]   diff;
  logic                           fits;
  logic [urd_pkg::DATA_WIDTH-1:0] rem_next;
  logic [urd_pkg::DATA_WIDTH-1:0] nq_next;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial    = {prev.rem, prev.nq[urd_pkg::DATA_WIDTH-1]};
    diff     = trial - {1'b0, prev.dvsr};
    fits     = ~diff[urd_pkg::DATA_WIDTH];
    rem_next = fits ? diff[urd_pkg::DATA_WIDTH-1:0] : trial[urd_pkg::DATA_WIDTH-1:0];
    nq_next  = {prev.nq[urd_pkg::DATA_WIDTH-2:0], fits};
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (advance) begin
      cur.valid <= prev.valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (advance) begin
      cur.narrow <= prev.narrow;
      cur.rem    <= rem_next;
      cur.nq     <= nq_next;
      cur.dvsr   <= prev.dvsr;
    end
  end

endmodule

// ===== rtl/urd_checker.sv =====
module urd_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input urd_pkg::rsp_item_t rsp
);

  // Hold a stalled result item steady
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  // Accept a new item exactly when the output slot frees up
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("request ready does not follow output slot");

  // Show no result right after reset
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result item present right after reset");

  // Present only fully known result items
  a_rsp_known: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !$isunknown(rsp))
    else $error("result item carries unknown bits");

endmodule

bind unsigned_restoring_divider urd_checker u_urd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
